// File: hdl/sorted_linked_queue_assert.svh
// Assertion macros for the sorted linked queue.
`ifndef SORTED_LINKED_QUEUE_ASSERT_SVH
`define SORTED_LINKED_QUEUE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SLQ_ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define SLQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/slq_pkg.sv
// Shared types and constants of the sorted linked queue.
`default_nettype none

package slq_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_FREE,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_LINK1,
    ST_LINK2,
    ST_POP_RD,
    ST_POP_CHK,
    ST_POP_UNLINK,
    ST_POP_FREE,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

// File: hdl/slq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module slq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/sorted_linked_queue.sv
// Sorted linked queue: node pool with a key-ordered doubly linked list.
//
// Input channel (in_valid_i/in_ready_o) takes one word per command: push key,
// pop handle, or query. Output channel (out_valid_o/out_ready_i) returns one
// word per command with status, the handle given on push, head and tail keys,
// head handle, entry count and an empty flag, all after the command.
// Commands are handled one at a time; in_ready_o is high only while no
// command is in work. A query goes straight to the response; a push answers
// at once if the pool is full, else takes a node off the free chain, walks
// back from the tail past at most the entry count of nodes while their keys
// are above its own, and links the new node. A pop reads and checks the node
// (a handle not in use is answered there), unlinks it and frees it. Each
// walk step reads one node from the key and link RAMs and compares keys in
// the next cycle. After reset the link RAMs are initialized one node per
// cycle, with in_ready_o low; the queue then starts empty.
// A finished result is held in the output register while the receiver
// stalls; the next command may be accepted meanwhile, and its result waits
// until the output register is free.
`default_nettype none

`include "sorted_linked_queue_assert.svh"

module sorted_linked_queue #(
  parameter int unsigned NODE_COUNT = 16,
  parameter int unsigned KEY_BITS   = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [slq_pkg::CMD_W-1:0]      command_i,
  input  wire logic [slq_pkg::KEY_W-1:0]      key_i,
  input  wire logic [slq_pkg::HANDLE_W-1:0]   handle_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [slq_pkg::STATUS_W-1:0]   status_o,
  output logic      [slq_pkg::HANDLE_W-1:0]   new_handle_o,
  output logic      [slq_pkg::KEY_W-1:0]      head_key_o,
  output logic      [slq_pkg::KEY_W-1:0]      tail_key_o,
  output logic      [slq_pkg::HANDLE_W-1:0]   head_handle_o,
  output logic      [slq_pkg::COUNT_W-1:0]    entry_count_o,
  output logic                                is_empty_o
);

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam int unsigned PW = $clog2(NODE_COUNT + 1);
  localparam logic [PW-1:0] END_PTR  = PW'(NODE_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODE_COUNT - 1);

  slq_pkg::state_e state_q, state_d;

  logic [IW-1:0] clr_q, clr_d;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [PW-1:0] free_q, free_d;
  logic [PW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;

  logic [KEY_BITS-1:0]          key_q, key_d;
  logic [slq_pkg::HANDLE_W-1:0] hdl_q, hdl_d;
  logic [IW-1:0]                node_q, node_d;
  logic [PW-1:0]                prv_q, prv_d;
  logic [PW-1:0]                nxt_q, nxt_d;
  logic [KEY_BITS-1:0]          head_key_q, head_key_d;
  logic [KEY_BITS-1:0]          tail_key_q, tail_key_d;
  logic [slq_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [slq_pkg::HANDLE_W-1:0] res_handle_q, res_handle_d;

  logic [slq_pkg::STATUS_W-1:0] o_status_q, o_status_d;
  logic [slq_pkg::HANDLE_W-1:0] o_new_handle_q, o_new_handle_d;
  logic [slq_pkg::KEY_W-1:0]    o_head_key_q, o_head_key_d;
  logic [slq_pkg::KEY_W-1:0]    o_tail_key_q, o_tail_key_d;
  logic [slq_pkg::HANDLE_W-1:0] o_head_handle_q, o_head_handle_d;
  logic [slq_pkg::COUNT_W-1:0]  o_count_q, o_count_d;
  logic                         o_empty_q, o_empty_d;

  logic                key_we;
  logic [IW-1:0]       key_waddr, key_raddr;
  logic [KEY_BITS-1:0] key_rdata;
  logic                next_we;
  logic [IW-1:0]       next_waddr;
  logic [PW-1:0]       next_wdata, next_rdata;
  logic                prev_we;
  logic [IW-1:0]       prev_waddr;
  logic [PW-1:0]       prev_wdata, prev_rdata;
  logic                use_we;
  logic [IW-1:0]       use_waddr;
  logic                use_wdata, use_rdata;
  logic [IW-1:0]       link_raddr;

  logic [IW-1:0] hdl_idx;
  logic          hdl_in_range;
  logic          empty;

  assign hdl_idx      = IW'(hdl_q);
  assign hdl_in_range = 32'(hdl_q) < NODE_COUNT;
  assign empty        = (count_q == '0);

  slq_ram #(.WIDTH(KEY_BITS), .DEPTH(NODE_COUNT)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  slq_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (link_raddr),
    .rdata_o (next_rdata)
  );

  slq_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (link_raddr),
    .rdata_o (prev_rdata)
  );

  slq_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_use_ram (
    .clk_i   (clk_i),
    .we_i    (use_we),
    .waddr_i (use_waddr),
    .wdata_i (use_wdata),
    .raddr_i (link_raddr),
    .rdata_o (use_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_d       = free_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    key_d        = key_q;
    hdl_d        = hdl_q;
    node_d       = node_q;
    prv_d        = prv_q;
    nxt_d        = nxt_q;
    head_key_d   = head_key_q;
    tail_key_d   = tail_key_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;

    o_status_d      = o_status_q;
    o_new_handle_d  = o_new_handle_q;
    o_head_key_d    = o_head_key_q;
    o_tail_key_d    = o_tail_key_q;
    o_head_handle_d = o_head_handle_q;
    o_count_d       = o_count_q;
    o_empty_d       = o_empty_q;

    key_we     = 1'b0;
    key_waddr  = node_q;
    key_raddr  = prv_q[IW-1:0];
    next_we    = 1'b0;
    next_waddr = node_q;
    next_wdata = nxt_q;
    prev_we    = 1'b0;
    prev_waddr = node_q;
    prev_wdata = prv_q;
    use_we     = 1'b0;
    use_waddr  = node_q;
    use_wdata  = 1'b0;
    link_raddr = prv_q[IW-1:0];
    in_ready_o = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      slq_pkg::ST_CLEAR: begin
        next_we    = 1'b1;
        next_waddr = clr_q;
        next_wdata = PW'(clr_q) + PW'(1);
        prev_we    = 1'b1;
        prev_waddr = clr_q;
        prev_wdata = END_PTR;
        use_we     = 1'b1;
        use_waddr  = clr_q;
        use_wdata  = 1'b0;
        clr_d      = clr_q + IW'(1);
        if (clr_q == LAST_IDX) begin
          state_d = slq_pkg::ST_IDLE;
        end
      end
      slq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d        = key_i[KEY_BITS-1:0];
          hdl_d        = handle_i;
          res_status_d = slq_pkg::STATUS_OK;
          res_handle_d = '0;
          case (command_i)
            slq_pkg::CMD_PUSH: state_d = slq_pkg::ST_PUSH_RD;
            slq_pkg::CMD_POP:  state_d = slq_pkg::ST_POP_RD;
            default:           state_d = slq_pkg::ST_RESP;
          endcase
        end
      end
      slq_pkg::ST_PUSH_RD: begin
        if (free_q == END_PTR) begin
          res_status_d = slq_pkg::STATUS_FULL;
          state_d      = slq_pkg::ST_RESP;
        end else begin
          link_raddr = free_q[IW-1:0];
          node_d     = free_q[IW-1:0];
          prv_d      = tail_q;
          state_d    = slq_pkg::ST_PUSH_FREE;
        end
      end
      slq_pkg::ST_PUSH_FREE: begin
        free_d  = next_rdata;
        state_d = slq_pkg::ST_WALK_RD;
      end
      slq_pkg::ST_WALK_RD: begin
        if (prv_q == END_PTR) begin
          state_d = slq_pkg::ST_LINK1;
        end else begin
          link_raddr = prv_q[IW-1:0];
          key_raddr  = prv_q[IW-1:0];
          state_d    = slq_pkg::ST_WALK_CMP;
        end
      end
      slq_pkg::ST_WALK_CMP: begin
        if (key_rdata > key_q) begin
          prv_d   = prev_rdata;
          state_d = slq_pkg::ST_WALK_RD;
        end else begin
          nxt_d   = next_rdata;
          state_d = slq_pkg::ST_LINK1;
        end
      end
      slq_pkg::ST_LINK1: begin
        next_we      = 1'b1;
        next_waddr   = node_q;
        next_wdata   = (prv_q == END_PTR) ? head_q : nxt_q;
        prev_we      = 1'b1;
        prev_waddr   = node_q;
        prev_wdata   = prv_q;
        use_we       = 1'b1;
        use_waddr    = node_q;
        use_wdata    = 1'b1;
        key_we       = 1'b1;
        key_waddr    = node_q;
        res_handle_d = slq_pkg::HANDLE_W'(node_q);
        state_d      = slq_pkg::ST_LINK2;
      end
      slq_pkg::ST_LINK2: begin
        count_d = count_q + PW'(1);
        if (prv_q == END_PTR) begin
          head_d     = PW'(node_q);
          head_key_d = key_q;
          if (head_q != END_PTR) begin
            prev_we    = 1'b1;
            prev_waddr = head_q[IW-1:0];
            prev_wdata = PW'(node_q);
          end else begin
            tail_d     = PW'(node_q);
            tail_key_d = key_q;
          end
        end else begin
          next_we    = 1'b1;
          next_waddr = prv_q[IW-1:0];
          next_wdata = PW'(node_q);
          if (nxt_q != END_PTR) begin
            prev_we    = 1'b1;
            prev_waddr = nxt_q[IW-1:0];
            prev_wdata = PW'(node_q);
          end else begin
            tail_d     = PW'(node_q);
            tail_key_d = key_q;
          end
        end
        state_d = slq_pkg::ST_RESP;
      end
      slq_pkg::ST_POP_RD: begin
        if (!hdl_in_range) begin
          res_status_d = slq_pkg::STATUS_INVALID;
          state_d      = slq_pkg::ST_RESP;
        end else begin
          link_raddr = hdl_idx;
          node_d     = hdl_idx;
          state_d    = slq_pkg::ST_POP_CHK;
        end
      end
      slq_pkg::ST_POP_CHK: begin
        if (!use_rdata) begin
          res_status_d = slq_pkg::STATUS_INVALID;
          state_d      = slq_pkg::ST_RESP;
        end else begin
          prv_d   = prev_rdata;
          nxt_d   = next_rdata;
          state_d = slq_pkg::ST_POP_UNLINK;
        end
      end
      slq_pkg::ST_POP_UNLINK: begin
        use_we    = 1'b1;
        use_waddr = node_q;
        use_wdata = 1'b0;
        if (prv_q != END_PTR) begin
          next_we    = 1'b1;
          next_waddr = prv_q[IW-1:0];
          next_wdata = nxt_q;
        end else begin
          head_d = nxt_q;
        end
        if (nxt_q != END_PTR) begin
          prev_we    = 1'b1;
          prev_waddr = nxt_q[IW-1:0];
          prev_wdata = prv_q;
        end else begin
          tail_d = prv_q;
        end
        key_raddr = (prv_q == END_PTR) ? nxt_q[IW-1:0] : prv_q[IW-1:0];
        state_d   = slq_pkg::ST_POP_FREE;
      end
      slq_pkg::ST_POP_FREE: begin
        next_we    = 1'b1;
        next_waddr = node_q;
        next_wdata = free_q;
        prev_we    = 1'b1;
        prev_waddr = node_q;
        prev_wdata = END_PTR;
        free_d     = PW'(node_q);
        count_d    = count_q - PW'(1);
        if (prv_q == END_PTR && nxt_q != END_PTR) begin
          head_key_d = key_rdata;
        end
        if (nxt_q == END_PTR && prv_q != END_PTR) begin
          tail_key_d = key_rdata;
        end
        state_d = slq_pkg::ST_RESP;
      end
      slq_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          o_status_d      = res_status_q;
          o_new_handle_d  = res_handle_q;
          o_head_key_d    = empty ? '0 : slq_pkg::KEY_W'(head_key_q);
          o_tail_key_d    = empty ? '0 : slq_pkg::KEY_W'(tail_key_q);
          o_head_handle_d = empty ? '0 : slq_pkg::HANDLE_W'(head_q);
          o_count_d       = slq_pkg::COUNT_W'(count_q);
          o_empty_d       = empty;
          state_d         = slq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = slq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slq_pkg::ST_CLEAR;
      clr_q       <= '0;
      head_q      <= END_PTR;
      tail_q      <= END_PTR;
      free_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q           <= key_d;
    hdl_q           <= hdl_d;
    node_q          <= node_d;
    prv_q           <= prv_d;
    nxt_q           <= nxt_d;
    head_key_q      <= head_key_d;
    tail_key_q      <= tail_key_d;
    res_status_q    <= res_status_d;
    res_handle_q    <= res_handle_d;
    o_status_q      <= o_status_d;
    o_new_handle_q  <= o_new_handle_d;
    o_head_key_q    <= o_head_key_d;
    o_tail_key_q    <= o_tail_key_d;
    o_head_handle_q <= o_head_handle_d;
    o_count_q       <= o_count_d;
    o_empty_q       <= o_empty_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign new_handle_o  = o_new_handle_q;
  assign head_key_o    = o_head_key_q;
  assign tail_key_o    = o_tail_key_q;
  assign head_handle_o = o_head_handle_q;
  assign entry_count_o = o_count_q;
  assign is_empty_o    = o_empty_q;

  `SLQ_ASSERT_HOLDS(a_count_bound, count_q <= END_PTR, "entry count above pool size")
  `SLQ_ASSERT_HOLDS(a_head_empty,
    (state_q == slq_pkg::ST_IDLE) |-> ((count_q == '0) == (head_q == END_PTR)),
    "head pointer disagrees with entry count")
  `SLQ_ASSERT_HOLDS(a_tail_empty,
    (state_q == slq_pkg::ST_IDLE) |-> ((count_q == '0) == (tail_q == END_PTR)),
    "tail pointer disagrees with entry count")
  `SLQ_ASSERT_HOLDS(a_free_full,
    (state_q == slq_pkg::ST_IDLE) |-> ((free_q == END_PTR) == (count_q == END_PTR)),
    "free chain disagrees with entry count")
  `SLQ_ASSERT_NEXT(a_full_hold,
    state_q == slq_pkg::ST_PUSH_RD && free_q == END_PTR, $stable(count_q),
    "full push changed entry count")

endmodule

`default_nettype wire

// File: sim/sorted_linked_queue_checker.sv
// Checker for the sorted linked queue: predicts each result word and compares it.
module sorted_linked_queue_checker #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [slq_pkg::CMD_W-1:0]       command_i,
  input  logic [slq_pkg::KEY_W-1:0]       key_i,
  input  logic [slq_pkg::HANDLE_W-1:0]    handle_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [slq_pkg::STATUS_W-1:0]    status_i,
  input  logic [slq_pkg::HANDLE_W-1:0]    new_handle_i,
  input  logic [slq_pkg::KEY_W-1:0]       head_key_i,
  input  logic [slq_pkg::KEY_W-1:0]       tail_key_i,
  input  logic [slq_pkg::HANDLE_W-1:0]    head_handle_i,
  input  logic [slq_pkg::COUNT_W-1:0]     entry_count_i,
  input  logic                            is_empty_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output logic [NODE_COUNT-1:0]           live_nodes_o
);

  localparam int unsigned LINK_W = $clog2(NODE_COUNT) + 1;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(NODE_COUNT);

  typedef struct packed {
    logic [slq_pkg::STATUS_W-1:0] status;
    logic [slq_pkg::HANDLE_W-1:0] new_handle;
    logic [slq_pkg::KEY_W-1:0]    head_key;
    logic [slq_pkg::KEY_W-1:0]    tail_key;
    logic [slq_pkg::HANDLE_W-1:0] head_handle;
    logic [slq_pkg::COUNT_W-1:0]  entry_count;
    logic                         is_empty;
  } queue_report_t;

  logic [slq_pkg::KEY_W-1:0]   node_key  [NODE_COUNT];
  logic [LINK_W-1:0]           node_next [NODE_COUNT];
  logic [LINK_W-1:0]           node_prev [NODE_COUNT];
  logic [NODE_COUNT-1:0]       node_live;
  logic [LINK_W-1:0]           head_idx;
  logic [LINK_W-1:0]           tail_idx;
  logic [LINK_W-1:0]           free_idx;
  logic [slq_pkg::COUNT_W-1:0] live_count;

  queue_report_t awaited_reports [$];
  int unsigned   mismatch_count;

  task automatic clear_pool();
    for (int i = 0; i < NODE_COUNT; i++) begin
      node_key[i]  = '0;
      node_next[i] = LINK_W'(i + 1);
      node_prev[i] = END_MARK;
    end
    node_live  = '0;
    head_idx   = END_MARK;
    tail_idx   = END_MARK;
    free_idx   = '0;
    live_count = '0;
  endtask

  task automatic apply_command(input logic [slq_pkg::CMD_W-1:0] cmd,
                               input logic [slq_pkg::KEY_W-1:0] key,
                               input logic [slq_pkg::HANDLE_W-1:0] hdl,
                               output queue_report_t rpt);
    logic [LINK_W-1:0] node;
    logic [LINK_W-1:0] walk;
    logic [LINK_W-1:0] prior;
    logic [LINK_W-1:0] after;
    rpt = '0;
    if (cmd == slq_pkg::CMD_PUSH) begin
      if (free_idx != END_MARK) begin
        node = free_idx;
        walk = tail_idx;
        free_idx = node_next[node];
        node_key[node] = key;
        node_live[node] = 1'b1;
        live_count++;
        while (walk != END_MARK && node_key[walk] > key)
          walk = node_prev[walk];
        if (walk == END_MARK) begin
          node_prev[node] = END_MARK;
          node_next[node] = head_idx;
          if (head_idx != END_MARK) node_prev[head_idx] = node;
          else tail_idx = node;
          head_idx = node;
        end else begin
          after = node_next[walk];
          node_next[walk] = node;
          node_prev[node] = walk;
          node_next[node] = after;
          if (after != END_MARK) node_prev[after] = node;
          else tail_idx = node;
        end
        rpt.new_handle = slq_pkg::HANDLE_W'(node);
      end else begin
        rpt.status = slq_pkg::STATUS_FULL;
      end
    end else if (cmd == slq_pkg::CMD_POP) begin
      if (hdl < NODE_COUNT && node_live[hdl]) begin
        prior = node_prev[hdl];
        after = node_next[hdl];
        if (prior != END_MARK) node_next[prior] = after;
        else head_idx = after;
        if (after != END_MARK) node_prev[after] = prior;
        else tail_idx = prior;
        node_next[hdl] = free_idx;
        node_prev[hdl] = END_MARK;
        node_live[hdl] = 1'b0;
        free_idx = LINK_W'(hdl);
        live_count--;
      end else begin
        rpt.status = slq_pkg::STATUS_INVALID;
      end
    end
    if (head_idx != END_MARK && tail_idx != END_MARK) begin
      rpt.head_key    = node_key[head_idx];
      rpt.tail_key    = node_key[tail_idx];
      rpt.head_handle = slq_pkg::HANDLE_W'(head_idx);
    end
    rpt.entry_count = live_count;
    rpt.is_empty    = (live_count == 0);
  endtask

  task automatic show_report(input string tag, input queue_report_t rpt);
    $write("  %s status %0d new_handle %0d", tag, rpt.status, rpt.new_handle);
    $display(" head_key %h tail_key %h head_handle %0d count %0d empty %0b",
             rpt.head_key, rpt.tail_key, rpt.head_handle, rpt.entry_count, rpt.is_empty);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_report_t seen;
    queue_report_t wanted;
    if (!rst_ni) begin
      clear_pool();
      awaited_reports.delete();
      mismatch_count = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      live_nodes_o <= '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = {status_i, new_handle_i, head_key_i, tail_key_i, head_handle_i,
                entry_count_i, is_empty_i};
        if (awaited_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: result word with no command waiting");
            show_report("got     ", seen);
          end
        end else begin
          wanted = awaited_reports.pop_front();
          if (seen !== wanted) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: result word differs");
              show_report("expected", wanted);
              show_report("got     ", seen);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_command(command_i, key_i, handle_i, wanted);
        awaited_reports.push_back(wanted);
      end
      fail_count_o <= mismatch_count;
      pending_o    <= awaited_reports.size();
      live_nodes_o <= node_live;
    end
  end

endmodule

// File: sim/sorted_linked_queue_test.sv
// Testbench top for the sorted linked queue: stimulus, idling phases and verdict.
module sorted_linked_queue_test;

  localparam logic [slq_pkg::CMD_W-1:0] CMD_SPARE   = 2'd3;
  localparam int unsigned               CYCLE_LIMIT = 400000;
  localparam int unsigned               PHASE_WORDS = 232;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [slq_pkg::CMD_W-1:0]    command = slq_pkg::CMD_QUERY;
  logic [slq_pkg::KEY_W-1:0]    key = '0;
  logic [slq_pkg::HANDLE_W-1:0] handle = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [slq_pkg::STATUS_W-1:0] status;
  logic [slq_pkg::HANDLE_W-1:0] new_handle;
  logic [slq_pkg::KEY_W-1:0]    head_key;
  logic [slq_pkg::KEY_W-1:0]    tail_key;
  logic [slq_pkg::HANDLE_W-1:0] head_handle;
  logic [slq_pkg::COUNT_W-1:0]  entry_count;
  logic                         is_empty;

  int unsigned fail_count;
  int unsigned pending;
  logic [15:0] live_nodes;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_linked_queue dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .key_i         (key),
    .handle_i      (handle),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .new_handle_o  (new_handle),
    .head_key_o    (head_key),
    .tail_key_o    (tail_key),
    .head_handle_o (head_handle),
    .entry_count_o (entry_count),
    .is_empty_o    (is_empty)
  );

  sorted_linked_queue_checker #(.NODE_COUNT(16)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .command_i     (command),
    .key_i         (key),
    .handle_i      (handle),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .new_handle_i  (new_handle),
    .head_key_i    (head_key),
    .tail_key_i    (tail_key),
    .head_handle_i (head_handle),
    .entry_count_i (entry_count),
    .is_empty_i    (is_empty),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .live_nodes_o  (live_nodes)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [slq_pkg::KEY_W-1:0] random_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return slq_pkg::KEY_W'($urandom_range(15));
    if (roll < 45) return '0;
    if (roll < 50) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [slq_pkg::HANDLE_W-1:0] pick_live(input logic [15:0] mask);
    int unsigned total;
    int unsigned target;
    int unsigned seen;
    logic [slq_pkg::HANDLE_W-1:0] pick;
    total = $countones(mask);
    pick = slq_pkg::HANDLE_W'($urandom_range(15));
    if (total != 0 && $urandom_range(99) < 85) begin
      target = $urandom_range(total - 1);
      seen = 0;
      for (int i = 0; i < 16; i++) begin
        if (mask[i]) begin
          if (seen == target) pick = slq_pkg::HANDLE_W'(i);
          seen++;
        end
      end
    end
    return pick;
  endfunction

  task automatic send_word(input logic [slq_pkg::CMD_W-1:0] cmd,
                           input logic [slq_pkg::KEY_W-1:0] k,
                           input logic [slq_pkg::HANDLE_W-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    key      <= k;
    handle   <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int unsigned roll;
    int unsigned push_pct;
    logic [slq_pkg::CMD_W-1:0] cmd;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_word(slq_pkg::CMD_QUERY, random_key(), 4'd0);
    send_word(slq_pkg::CMD_POP, random_key(), 4'd0);
    send_word(CMD_SPARE, random_key(), 4'd9);
    send_word(slq_pkg::CMD_PUSH, '1, 4'd15);
    send_word(slq_pkg::CMD_PUSH, '0, 4'd0);
    send_word(slq_pkg::CMD_PUSH, 64'd5, 4'd5);
    send_word(slq_pkg::CMD_PUSH, 64'd5, 4'd10);
    send_word(slq_pkg::CMD_PUSH, 64'd5, 4'd0);
    send_word(slq_pkg::CMD_PUSH, 64'h8000_0000_0000_0000, 4'd0);
    send_word(slq_pkg::CMD_POP, random_key(), 4'd15);
    repeat (10) begin
      send_word(slq_pkg::CMD_PUSH, random_key(), slq_pkg::HANDLE_W'($urandom_range(15)));
    end
    send_word(slq_pkg::CMD_PUSH, 64'd7, 4'd0);
    send_word(slq_pkg::CMD_POP, random_key(), 4'd1);
    send_word(slq_pkg::CMD_POP, random_key(), 4'd0);
    send_word(slq_pkg::CMD_POP, random_key(), 4'd3);
    send_word(slq_pkg::CMD_POP, random_key(), 4'd3);
    send_word(slq_pkg::CMD_PUSH, 64'd5, 4'd0);
    send_word(slq_pkg::CMD_QUERY, random_key(), 4'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 78; end
        default: begin send_idle_pct = 35; recv_stall_pct <= 35; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        push_pct = ((n / 40) % 2 == 0) ? 62 : 25;
        roll = $urandom_range(99);
        if (roll < 5) cmd = slq_pkg::CMD_QUERY;
        else if (roll < 8) cmd = CMD_SPARE;
        else if (roll < 8 + push_pct) cmd = slq_pkg::CMD_PUSH;
        else cmd = slq_pkg::CMD_POP;
        send_word(cmd, random_key(), pick_live(live_nodes));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
